// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication checked in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication checked in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/lrdf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrdf_pkg
// Types, codes and hash helpers for the log record deframer.
// ----------------------------------------------------------------------------
package lrdf_pkg;

	// FNV-1a 32-bit constants
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	// Parser phases
	typedef enum logic [2:0] {
		PH_OP   = 3'd0,
		PH_KLEN = 3'd1,
		PH_KEY  = 3'd2,
		PH_VLEN = 3'd3,
		PH_VAL  = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_KEY    = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	// Record status codes
	localparam logic [1:0] ST_GOOD  = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	// One result beat
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload;
		logic [7:0]  op;
		logic [31:0] klen;
		logic [31:0] vlen;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// Results produced by one input byte (zero, one or two)
	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} push_t;

	// One FNV-1a step; the multiply is by a constant
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

	// Place a byte into a little-endian word at byte lane idx
	function automatic logic [31:0] put_le(input logic [31:0] acc, input logic [7:0] b,
		input logic [1:0] idx);
		return acc | ({24'd0, b} << {idx, 3'b000});
	endfunction

endpackage

// ===== src/lrdf_parser.sv =====
// ----------------------------------------------------------------------------
// lrdf_parser
// Record parser: one byte per accepted beat, FNV-1a hash, result generation.
// ----------------------------------------------------------------------------
module lrdf_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          log_byte,
	input  logic                stream_end,
	output lrdf_pkg::push_t     push
);

	lrdf_pkg::phase_t phase_q, n_phase;
	logic [1:0]  idx_q, n_idx;
	logic [31:0] rem_q, n_rem;
	logic [31:0] hash_q, n_hash;
	logic [31:0] csum_q, n_csum;
	logic [7:0]  op_q, n_op;
	logic [31:0] klen_q, n_klen;
	logic [31:0] vlen_q, n_vlen;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrdf_pkg::PH_OP;
			idx_q   <= 2'd0;
			rem_q   <= 32'd0;
			hash_q  <= lrdf_pkg::FNV_BASIS;
			csum_q  <= 32'd0;
			op_q    <= 8'd0;
			klen_q  <= 32'd0;
			vlen_q  <= 32'd0;
		end else if (accept) begin
			phase_q <= n_phase;
			idx_q   <= n_idx;
			rem_q   <= n_rem;
			hash_q  <= n_hash;
			csum_q  <= n_csum;
			op_q    <= n_op;
			klen_q  <= n_klen;
			vlen_q  <= n_vlen;
		end
	end

	// Next state and results for the byte on the input
	always_comb begin
		lrdf_pkg::result_t first, trunc;
		logic has_first;
		logic has_trunc;

		n_phase = phase_q;
		n_idx   = idx_q;
		n_rem   = rem_q;
		n_hash  = hash_q;
		n_csum  = csum_q;
		n_op    = op_q;
		n_klen  = klen_q;
		n_vlen  = vlen_q;
		has_first = 1'b0;
		first = '0;
		trunc = '0;

		case (phase_q)
			lrdf_pkg::PH_KLEN: begin
				n_klen = lrdf_pkg::put_le(klen_q, log_byte, idx_q);
				if (idx_q == 2'd3) begin
					n_idx = 2'd0;
					n_rem = n_klen;
					n_phase = (n_klen == 32'd0) ? lrdf_pkg::PH_VLEN : lrdf_pkg::PH_KEY;
				end else begin
					n_idx = idx_q + 2'd1;
				end
			end
			lrdf_pkg::PH_KEY: begin
				n_hash = lrdf_pkg::fnv_step(hash_q, log_byte);
				has_first = 1'b1;
				first.kind = lrdf_pkg::KIND_KEY;
				first.payload = log_byte;
				n_rem = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					n_phase = lrdf_pkg::PH_VLEN;
				end
			end
			lrdf_pkg::PH_VLEN: begin
				n_vlen = lrdf_pkg::put_le(vlen_q, log_byte, idx_q);
				if (idx_q == 2'd3) begin
					n_idx = 2'd0;
					n_rem = n_vlen;
					n_phase = (n_vlen == 32'd0) ? lrdf_pkg::PH_CSUM : lrdf_pkg::PH_VAL;
				end else begin
					n_idx = idx_q + 2'd1;
				end
			end
			lrdf_pkg::PH_VAL: begin
				n_hash = lrdf_pkg::fnv_step(hash_q, log_byte);
				has_first = 1'b1;
				first.kind = lrdf_pkg::KIND_VALUE;
				first.payload = log_byte;
				n_rem = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					n_phase = lrdf_pkg::PH_CSUM;
				end
			end
			lrdf_pkg::PH_CSUM: begin
				n_csum = lrdf_pkg::put_le(csum_q, log_byte, idx_q);
				if (idx_q == 2'd3) begin
					n_idx = 2'd0;
					has_first = 1'b1;
					first.kind = lrdf_pkg::KIND_REPORT;
					first.op = op_q;
					first.klen = klen_q;
					first.vlen = vlen_q;
					first.status = (n_csum == hash_q) ? lrdf_pkg::ST_GOOD : lrdf_pkg::ST_BAD;
					n_phase = lrdf_pkg::PH_OP;
				end else begin
					n_idx = idx_q + 2'd1;
				end
			end
			default: begin
				// operation byte; unused phase codes land here too
				n_op    = log_byte;
				n_klen  = 32'd0;
				n_vlen  = 32'd0;
				n_csum  = 32'd0;
				n_idx   = 2'd0;
				n_rem   = 32'd0;
				n_hash  = lrdf_pkg::FNV_BASIS;
				n_phase = lrdf_pkg::PH_KLEN;
			end
		endcase

		// Stream ended inside a record: truncation report, back to idle
		has_trunc = stream_end && (n_phase != lrdf_pkg::PH_OP);
		trunc.kind = lrdf_pkg::KIND_REPORT;
		trunc.op = n_op;
		trunc.klen = n_klen;
		trunc.vlen = n_vlen;
		trunc.status = lrdf_pkg::ST_TRUNC;
		trunc.last = 1'b1;
		if (has_trunc) begin
			n_phase = lrdf_pkg::PH_OP;
			n_idx = 2'd0;
			n_rem = 32'd0;
		end

		// Pack results in order; the final one carries last
		first.last = !has_trunc;
		push.cnt = {1'b0, has_first} + {1'b0, has_trunc};
		push.res0 = has_first ? first : trunc;
		push.res1 = trunc;
	end

endmodule

// ===== src/lrdf_outq.sv =====
// ----------------------------------------------------------------------------
// lrdf_outq
// Three-entry result queue; head is always entry zero.
// ----------------------------------------------------------------------------
module lrdf_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  lrdf_pkg::push_t     push,
	input  logic                rec_stall,
	output logic                rec_valid,
	output lrdf_pkg::result_t   head,
	output logic                full
);

	lrdf_pkg::result_t ent_q [3];
	lrdf_pkg::result_t n_ent [3];
	logic [1:0] cnt_q, n_cnt;
	logic [1:0] base;
	logic       pop;

	assign rec_valid = (cnt_q != 2'd0);
	assign head = ent_q[0];
	// room for two more results must remain before a byte is taken
	assign full = cnt_q[1];
	assign pop = rec_valid && !rec_stall;
	assign base = cnt_q - {1'b0, pop};

	// Shift on pop, then write new results behind the survivors
	always_comb begin
		n_ent[0] = pop ? ent_q[1] : ent_q[0];
		n_ent[1] = pop ? ent_q[2] : ent_q[1];
		n_ent[2] = ent_q[2];
		for (int i = 0; i < 3; i++) begin
			if (push_en && push.cnt != 2'd0 && base == i[1:0]) begin
				n_ent[i] = push.res0;
			end
			if (push_en && push.cnt == 2'd2 && (base + 2'd1) == i[1:0]) begin
				n_ent[i] = push.res1;
			end
		end
		n_cnt = base + (push_en ? push.cnt : 2'd0);
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= n_cnt;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ent_q[i] <= n_ent[i];
		end
	end

endmodule

// ===== src/log_record_deframer_fnv_check.sv =====
// ----------------------------------------------------------------------------
// log_record_deframer_fnv_check
// Length-prefixed log record parser with FNV-1a 32-bit checksum check.
//
//   channel  | handshake             | beat contents
//   ---------+-----------------------+---------------------------------------
//   log      | log_valid / log_stall | log_byte, stream_end
//   rec      | rec_valid / rec_stall | item_kind, payload_byte, operation_code,
//            |                       | key_length, value_length,
//            |                       | record_status, last_of_run
//
// One log byte per cycle while log_stall is low; each byte gives zero, one or two result beats.
// Results are written into a three-entry queue when the byte is taken and show on
// rec from its head; log_stall is high while two or more results wait.
// Hash update and checksum compare are done in the cycle the byte is taken.
// arst_n clears the parser to waiting for an operation byte and empties the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log_record_deframer_fnv_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        log_valid,
	output logic        log_stall,
	input  logic [7:0]  log_byte,
	input  logic        stream_end,
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic [1:0]  item_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  operation_code,
	output logic [31:0] key_length,
	output logic [31:0] value_length,
	output logic [1:0]  record_status,
	output logic        last_of_run
);

	lrdf_pkg::push_t   push;
	lrdf_pkg::result_t head;
	logic              accept;
	logic              full;

	assign accept = log_valid && !log_stall;
	assign log_stall = full;

	// Parser
	lrdf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.log_byte   (log_byte),
		.stream_end (stream_end),
		.push       (push)
	);

	// Result queue
	lrdf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (accept),
		.push      (push),
		.rec_stall (rec_stall),
		.rec_valid (rec_valid),
		.head      (head),
		.full      (full)
	);

	assign item_kind      = head.kind;
	assign payload_byte   = head.payload;
	assign operation_code = head.op;
	assign key_length     = head.klen;
	assign value_length   = head.vlen;
	assign record_status  = head.status;
	assign last_of_run    = head.last;

	// Checks
	`ASSERT_IMP(a_report_no_payload, clk, arst_n, rec_valid && item_kind == lrdf_pkg::KIND_REPORT, payload_byte == 8'd0, "report beat with nonzero payload")
	`ASSERT_IMP(a_data_no_header, clk, arst_n, rec_valid && item_kind != lrdf_pkg::KIND_REPORT, operation_code == 8'd0 && key_length == 32'd0 && value_length == 32'd0 && record_status == lrdf_pkg::ST_GOOD, "data beat with header fields set")
	`ASSERT_NEXT(a_trunc_follows, clk, arst_n, rec_valid && !rec_stall && item_kind != lrdf_pkg::KIND_REPORT && !last_of_run, rec_valid && item_kind == lrdf_pkg::KIND_REPORT && record_status == lrdf_pkg::ST_TRUNC, "data beat without last not followed by truncation report")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives length-prefixed log records into the deframer one byte per beat and
// checks every key, value and record end beat against a software copy of the
// parser, including the FNV-1a checksum verdict. Records are mostly
// well-formed, some carry bad checksums, and some are cut short by stream_end.
// Both channels idle at random, and the result side holds off for a long
// stretch once so that the input side backs up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_CAP  = 200;

	// Software copy of the parser plus the queue of beats it expects
	class deframe_tracker;
		lrdf_pkg::phase_t  phase;
		logic [1:0]        lane;
		logic [31:0]       remaining;
		logic [31:0]       hash;
		logic [31:0]       sum_seen;
		logic [7:0]        op;
		logic [31:0]       klen;
		logic [31:0]       vlen;
		lrdf_pkg::result_t expected_beats[$];
		int unsigned       errors;

		function new();
			phase = lrdf_pkg::PH_OP;
			lane = '0;
			remaining = '0;
			hash = lrdf_pkg::FNV_BASIS;
			sum_seen = '0;
			op = '0;
			klen = '0;
			vlen = '0;
			errors = 0;
		endfunction

		static function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
			return (h ^ {24'd0, b}) * lrdf_pkg::FNV_PRIME;
		endfunction

		function lrdf_pkg::result_t make_beat(logic [1:0] kind, logic [7:0] data,
			logic [1:0] status);
			lrdf_pkg::result_t r;
			r = '0;
			r.kind = kind;
			r.payload = data;
			if (kind == lrdf_pkg::KIND_REPORT) begin
				r.op = op;
				r.klen = klen;
				r.vlen = vlen;
				r.status = status;
			end
			return r;
		endfunction

		// Advance the parser by one accepted log beat and queue what it yields
		function void note_log_beat(logic [7:0] b, logic last_in_stream);
			lrdf_pkg::result_t out[$];
			lrdf_pkg::result_t r;
			case (phase)
				lrdf_pkg::PH_OP: begin
					op = b;
					klen = '0;
					vlen = '0;
					sum_seen = '0;
					lane = '0;
					remaining = '0;
					hash = lrdf_pkg::FNV_BASIS;
					phase = lrdf_pkg::PH_KLEN;
				end
				lrdf_pkg::PH_KLEN: begin
					klen[8*lane +: 8] = b;
					if (lane == 2'd3) begin
						lane = '0;
						remaining = klen;
						phase = (klen == 0) ? lrdf_pkg::PH_VLEN : lrdf_pkg::PH_KEY;
					end else
						lane++;
				end
				lrdf_pkg::PH_KEY: begin
					hash = fold_byte(hash, b);
					out = {out, make_beat(lrdf_pkg::KIND_KEY, b, lrdf_pkg::ST_GOOD)};
					remaining--;
					if (remaining == 0)
						phase = lrdf_pkg::PH_VLEN;
				end
				lrdf_pkg::PH_VLEN: begin
					vlen[8*lane +: 8] = b;
					if (lane == 2'd3) begin
						lane = '0;
						remaining = vlen;
						phase = (vlen == 0) ? lrdf_pkg::PH_CSUM : lrdf_pkg::PH_VAL;
					end else
						lane++;
				end
				lrdf_pkg::PH_VAL: begin
					hash = fold_byte(hash, b);
					out = {out, make_beat(lrdf_pkg::KIND_VALUE, b, lrdf_pkg::ST_GOOD)};
					remaining--;
					if (remaining == 0)
						phase = lrdf_pkg::PH_CSUM;
				end
				default: begin
					sum_seen[8*lane +: 8] = b;
					if (lane == 2'd3) begin
						lane = '0;
						out = {out, make_beat(lrdf_pkg::KIND_REPORT, 8'd0,
							(sum_seen == hash) ? lrdf_pkg::ST_GOOD : lrdf_pkg::ST_BAD)};
						phase = lrdf_pkg::PH_OP;
					end else
						lane++;
				end
			endcase

			// stream ended inside a record: report what was held so far
			if (last_in_stream && phase != lrdf_pkg::PH_OP) begin
				out = {out, make_beat(lrdf_pkg::KIND_REPORT, 8'd0, lrdf_pkg::ST_TRUNC)};
				phase = lrdf_pkg::PH_OP;
				lane = '0;
				remaining = '0;
			end

			if (out.size() > 0)
				out[out.size()-1].last = 1'b1;
			foreach (out[i]) begin
				r = out[i];
				expected_beats = {expected_beats, r};
			end
		endfunction

		function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (want_v !== got_v) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
			end
		endfunction

		// Compare one accepted result beat against the oldest expectation
		function void check_rec_beat(lrdf_pkg::result_t got);
			lrdf_pkg::result_t want;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: result beat with nothing expected, expected none actual %h",
						$time, got);
				return;
			end
			want = expected_beats.pop_front();
			compare_field("item_kind", want.kind, got.kind);
			compare_field("payload_byte", want.payload, got.payload);
			compare_field("operation_code", want.op, got.op);
			compare_field("key_length", want.klen, got.klen);
			compare_field("value_length", want.vlen, got.vlen);
			compare_field("record_status", want.status, got.status);
			compare_field("last_of_run", want.last, got.last);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        log_valid;
	logic        log_stall;
	logic [7:0]  log_byte;
	logic        stream_end;
	logic        rec_valid;
	logic        rec_stall;
	logic [1:0]  item_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  operation_code;
	logic [31:0] key_length;
	logic [31:0] value_length;
	logic [1:0]  record_status;
	logic        last_of_run;

	lrdf_pkg::result_t rec_seen;
	deframe_tracker    tracker;
	int                log_beats_sent;
	int                cycle_count;
	logic              quiet;
	logic              hold_rec;

	log_record_deframer_fnv_check uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.log_valid      (log_valid),
		.log_stall      (log_stall),
		.log_byte       (log_byte),
		.stream_end     (stream_end),
		.rec_valid      (rec_valid),
		.rec_stall      (rec_stall),
		.item_kind      (item_kind),
		.payload_byte   (payload_byte),
		.operation_code (operation_code),
		.key_length     (key_length),
		.value_length   (value_length),
		.record_status  (record_status),
		.last_of_run    (last_of_run)
	);

	assign rec_seen = {item_kind, payload_byte, operation_code, key_length,
		value_length, record_status, last_of_run};

	// Clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("log_record_deframer_fnv_check regression: fail");
			$finish;
		end
	end

	// Result side: check accepted beats, stall at random or during the hold-off
	always @(posedge clk) begin
		if (rec_valid === 1'b1 && rec_stall === 1'b0)
			tracker.check_rec_beat(rec_seen);
		rec_stall <= hold_rec || (!quiet && $urandom_range(99, 0) < 17);
	end

	// Long hold-off on the result side so the input backs up
	initial begin
		hold_rec <= 1'b0;
		while (log_beats_sent < 200)
			@(posedge clk);
		hold_rec <= 1'b1;
		repeat (120) @(posedge clk);
		hold_rec <= 1'b0;
	end

	// Offer one log beat, idling first at random, and wait until it is taken
	task automatic send_log_beat(input logic [7:0] b, input logic last_in_stream);
		while (!quiet && $urandom_range(99, 0) < 17) begin
			log_valid <= 1'b0;
			@(posedge clk);
		end
		log_valid <= 1'b1;
		log_byte <= b;
		stream_end <= last_in_stream;
		do
			@(posedge clk);
		while (log_stall !== 1'b0);
		tracker.note_log_beat(b, last_in_stream);
		log_beats_sent++;
		quiet <= (log_beats_sent >= 350 && log_beats_sent < 500);
	endtask

	// Build one record with random key and value bytes; cut >= 0 puts
	// stream_end on that byte and drops the rest of the record
	task automatic send_record(input logic [7:0] op, input logic [31:0] klen,
		input logic [31:0] vlen, input bit bad_sum, input int cut);
		logic [7:0]  frame[$];
		logic [31:0] h;
		logic [7:0]  b;
		int          lim;
		lim = (cut < 0) ? 32'h7fffffff : cut + 1;
		h = lrdf_pkg::FNV_BASIS;
		frame = {frame, op};
		for (int i = 0; i < 4; i++)
			frame = {frame, klen[8*i +: 8]};
		for (longint j = 0; j < klen && frame.size() < lim; j++) begin
			b = 8'($urandom);
			h = deframe_tracker::fold_byte(h, b);
			frame = {frame, b};
		end
		for (int i = 0; i < 4; i++)
			frame = {frame, vlen[8*i +: 8]};
		for (longint j = 0; j < vlen && frame.size() < lim; j++) begin
			b = 8'($urandom);
			h = deframe_tracker::fold_byte(h, b);
			frame = {frame, b};
		end
		if (bad_sum)
			h = h ^ (32'd1 << $urandom_range(31, 0));
		for (int i = 0; i < 4; i++)
			frame = {frame, h[8*i +: 8]};
		for (int i = 0; i < frame.size() && i < lim; i++)
			send_log_beat(frame[i], i == cut);
	endtask

	// Stimulus and verdict
	initial begin
		int          pick;
		int          full;
		logic [31:0] klen_pick;
		logic [31:0] vlen_pick;

		arst_n = 1'b0;
		log_valid <= 1'b0;
		log_byte <= 8'd0;
		stream_end <= 1'b0;
		quiet <= 1'b0;
		log_beats_sent = 0;
		tracker = new();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty key and value, good checksum, stream ends on last checksum byte
		send_record(8'h00, 32'd0, 32'd0, 1'b0, 12);
		// stream ends on a key byte: key beat, then truncation report
		send_record(8'hFF, 32'd1, 32'd0, 1'b0, 5);
		// stream ends right on the operation byte
		send_record(8'h5A, 32'd0, 32'd0, 1'b0, 0);
		// stream ends mid key length: partial length in the report
		send_record(8'h33, 32'hFFFF_FF80, 32'd0, 1'b0, 2);

		// Random records: mostly well-formed, some cut short, some noise
		while (log_beats_sent < 750) begin
			pick = $urandom_range(99, 0);
			klen_pick = $urandom_range(6, 0);
			vlen_pick = $urandom_range(6, 0);
			full = 13 + klen_pick + vlen_pick;
			if (pick < 70)
				send_record(8'($urandom), klen_pick, vlen_pick, $urandom_range(3, 0) == 0,
					($urandom_range(9, 0) == 0) ? full - 1 : -1);
			else if (pick < 88)
				send_record(8'($urandom), klen_pick, vlen_pick, 1'b0,
					$urandom_range(full - 2, 0));
			else
				send_record(8'($urandom), $urandom, $urandom, 1'b0,
					$urandom_range(12, 0));
		end
		log_valid <= 1'b0;

		// Drain
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.errors == 0)
			$display("log_record_deframer_fnv_check regression: pass");
		else
			$display("log_record_deframer_fnv_check regression: fail");
		$finish;
	end

endmodule
